// ----- hw/rtl/sevm_pkg.sv -----
package sevm_pkg;

  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_HISS_TARGET   = 3'd1,
    OP_CRACKLE_SET   = 3'd2,
    OP_CRACKLE_RAISE = 3'd3,
    OP_NOTE          = 3'd4,
    OP_SLOT_WRITE    = 3'd5,
    OP_MELODY_START  = 3'd6,
    OP_SILENCE       = 3'd7
  } op_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_MELODY_AMPLITUDE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MELODY_GAP       = 1'b1;

  localparam logic [7:0]  MELODY_AMPLITUDE_RESET = 8'd34;
  localparam logic [6:0]  MELODY_GAP_RESET       = 7'd110;
  localparam logic [31:0] NOISE_SEED             = 32'h2545F491;

  localparam logic signed [10:0] MIDPOINT   = 11'sd128;
  localparam logic signed [10:0] SAMPLE_TOP = 11'sd255;
  localparam logic signed [9:0]  AMP_FLOOR  = -10'sd8;

  // Output sample rate in hertz.
  localparam longint unsigned SAMPLE_RATE   = 64'd22050;
  localparam longint unsigned MS_PER_SECOND = 64'd1000;

  // The phase increment (freq << 32) / rate is split into freq * whole + the
  // floor of freq * rem / rate.  The second term is an exact reciprocal
  // multiply with a 32-bit fractional scale, since freq and rate are below 2^16.
  localparam longint unsigned INC_WHOLE_FULL = (64'd1 << 32) / SAMPLE_RATE;
  localparam longint unsigned INC_REM_FULL   = (64'd1 << 32) % SAMPLE_RATE;
  localparam longint unsigned INC_FRAC_FULL  =
    ((INC_REM_FULL << 32) + SAMPLE_RATE - 64'd1) / SAMPLE_RATE;
  localparam logic [19:0] INC_WHOLE = 20'(INC_WHOLE_FULL);
  localparam logic [31:0] INC_FRAC  = 32'(INC_FRAC_FULL);

  // Tone length ms * rate / 1000 as one reciprocal multiply; an 18-bit
  // fraction keeps it exact for every 8-bit millisecond value.
  localparam int LEN_SHIFT = 18;
  localparam longint unsigned LEN_MULT_FULL =
    ((SAMPLE_RATE << LEN_SHIFT) + MS_PER_SECOND - 64'd1) / MS_PER_SECOND;
  localparam logic [23:0] LEN_MULT     = 24'(LEN_MULT_FULL);
  localparam logic [12:0] TONE_LEN_MAX = 13'd8191;

  typedef struct packed {
    logic [31:0] inc;
    logic [12:0] len;
  } tone_setup_t;

endpackage

// ----- hw/rtl/sevm_tone_calc.sv -----
module sevm_tone_calc (
  input  logic [15:0]                freq_hz,
  input  logic [7:0]                 duration_ms,
  output sevm_pkg::tone_setup_t      setup
);

  logic [35:0] whole_prod;
  logic [47:0] frac_prod;
  logic [31:0] len_prod;
  logic [31-sevm_pkg::LEN_SHIFT:0] len_raw;

  assign whole_prod = {20'd0, freq_hz} * {16'd0, sevm_pkg::INC_WHOLE};
  assign frac_prod  = {32'd0, freq_hz} * {16'd0, sevm_pkg::INC_FRAC};
  assign len_prod   = {24'd0, duration_ms} * {8'd0, sevm_pkg::LEN_MULT};
  assign len_raw    = len_prod[31:sevm_pkg::LEN_SHIFT];

  always_comb begin
    setup.inc = whole_prod[31:0] + {16'd0, frac_prod[47:32]};
    if (len_raw > (32-sevm_pkg::LEN_SHIFT)'(sevm_pkg::TONE_LEN_MAX)) begin
      setup.len = sevm_pkg::TONE_LEN_MAX;
    end else begin
      setup.len = len_raw[12:0];
    end
  end

endmodule

// ----- hw/rtl/sound_effect_voice_mixer_core.sv -----
// Channel   Direction  Signals                                              Beat
// in        input      in_valid/in_ready, operation, amount, freq_hz,       one command
//                      duration_ms, slot, count
// out       output     out_valid/out_ready, sample                          one sample
// cfg       input      cfg_we, cfg_index, cfg_data                          one register write
//
// One input beat is taken every cycle while in_ready is high. A beat goes through an
// input register and one pass of mixing logic; a tick's sample is then registered on
// the output. The tone multipliers sit before the input register. rst (synchronous)
// returns all voices, the slots and the registers.
// While out_ready is low a finished sample holds; a following tick waits in the
// input register and stops in_ready, while other commands pass.
module sound_effect_voice_mixer_core #(
  parameter int MELODY_SLOTS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         operation,
  input  logic [7:0]                         amount,
  input  logic [15:0]                        freq_hz,
  input  logic [7:0]                         duration_ms,
  input  logic [2:0]                         slot,
  input  logic [3:0]                         count,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         sample,
  input  logic                               cfg_we,
  input  logic [sevm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sevm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_W = $clog2(MELODY_SLOTS + 1);
  localparam int POS_W = (MELODY_SLOTS > 1) ? $clog2(MELODY_SLOTS) : 1;

  // Input register.
  logic                  pend_valid;
  logic                  pend_valid_next;
  sevm_pkg::op_t         pend_op;
  logic [7:0]            pend_amount;
  logic [2:0]            pend_slot;
  logic [3:0]            pend_count;
  sevm_pkg::tone_setup_t pend_setup;
  sevm_pkg::tone_setup_t port_setup;

  // Configuration.
  logic [7:0] melody_amplitude;
  logic [6:0] melody_gap;

  // Voice state.
  logic [31:0]        noise;
  logic [31:0]        noise_next;
  logic signed [7:0]  lowpass;
  logic signed [7:0]  lowpass_next;
  logic [7:0]         hiss_target;
  logic [7:0]         hiss_target_next;
  logic [7:0]         hiss_level;
  logic [7:0]         hiss_level_next;
  logic [7:0]         crackle;
  logic [7:0]         crackle_next;
  logic [31:0]        phase_acc;
  logic [31:0]        phase_acc_next;
  logic [31:0]        tone_inc;
  logic [31:0]        tone_inc_next;
  logic signed [9:0]  note_level;
  logic signed [9:0]  note_level_next;
  logic [12:0]        tone_remaining;
  logic [12:0]        tone_remaining_next;
  sevm_pkg::tone_setup_t slots [MELODY_SLOTS];
  logic [LEN_W-1:0]   melody_length;
  logic [LEN_W-1:0]   melody_length_next;
  logic [LEN_W-1:0]   melody_position;
  logic [LEN_W-1:0]   melody_position_next;
  logic [6:0]         gap_count;
  logic [6:0]         gap_count_next;

  // Output register.
  logic       out_valid_next;
  logic [7:0] sample_next;

  logic consume;
  logic slot_write;

  // Mixing terms.
  logic signed [8:0]  hiss_diff;
  logic signed [8:0]  hiss_sum;
  logic [7:0]         hiss_level_mix;
  logic [31:0]        r1;
  logic [31:0]        r2;
  logic [31:0]        r3;
  logic signed [7:0]  nz;
  logic signed [8:0]  lp_diff;
  logic signed [8:0]  lp_sum;
  logic signed [7:0]  lp_mix;
  logic signed [16:0] hiss_prod;
  logic signed [16:0] crackle_prod;
  logic signed [8:0]  crackle_term;
  logic [7:0]         crackle_mix;
  logic [31:0]        phase_mix;
  logic signed [9:0]  tone_term;
  logic [12:0]        remaining_mix;
  logic signed [9:0]  amp_bias;
  logic signed [9:0]  amp_div8;
  logic signed [9:0]  amp_faded;
  logic signed [10:0] mix_sum;
  logic [7:0]         mix_sample;
  logic [LEN_W-1:0]   count_sat;
  sevm_pkg::tone_setup_t melody_setup;

  sevm_tone_calc u_tone_calc (
    .freq_hz     (freq_hz),
    .duration_ms (duration_ms),
    .setup       (port_setup)
  );

  assign consume  = pend_valid &&
                    (pend_op != sevm_pkg::OP_TICK || !out_valid || out_ready);
  assign in_ready = !pend_valid || consume;

  // Hiss glide and lowpassed noise.
  assign hiss_diff      = $signed({1'b0, hiss_target}) - $signed({1'b0, hiss_level});
  assign hiss_sum       = $signed({1'b0, hiss_level}) + (hiss_diff >>> 5);
  assign hiss_level_mix = hiss_sum[7:0];
  assign r1             = noise ^ (noise << 13);
  assign r2             = r1 ^ (r1 >> 17);
  assign r3             = r2 ^ (r2 << 5);
  assign nz             = $signed({~r3[15], r3[14:8]});
  assign lp_diff        = $signed({nz[7], nz}) - $signed({lowpass[7], lowpass});
  assign lp_sum         = $signed({lowpass[7], lowpass}) + (lp_diff >>> 2);
  assign lp_mix         = lp_sum[7:0];
  assign hiss_prod      = lp_mix * $signed({1'b0, hiss_level_mix});

  // Crackle decays by level/64 + 1 per sample.
  assign crackle_prod = nz * $signed({1'b0, crackle});
  assign crackle_term = (crackle != 8'd0) ? crackle_prod[16:8] : 9'sd0;
  assign crackle_mix  = crackle - {6'd0, crackle[7:6]} - 8'd1;

  // Square tone with a truncating fade near its end.
  assign phase_mix     = phase_acc + tone_inc;
  assign remaining_mix = tone_remaining - 13'd1;
  assign amp_bias      = note_level + (note_level[9] ? 10'sd7 : 10'sd0);
  assign amp_div8      = amp_bias >>> 3;
  assign amp_faded     = note_level - amp_div8 - 10'sd1;

  always_comb begin
    if (tone_remaining == 13'd0) begin
      tone_term = 10'sd0;
    end else if (phase_mix[31]) begin
      tone_term = note_level;
    end else begin
      tone_term = -note_level;
    end
  end

  assign mix_sum = sevm_pkg::MIDPOINT
                 + $signed({{2{hiss_prod[16]}}, hiss_prod[16:8]})
                 + $signed({{2{crackle_term[8]}}, crackle_term})
                 + $signed({tone_term[9], tone_term});

  always_comb begin
    if (mix_sum < 11'sd0) begin
      mix_sample = 8'd0;
    end else if (mix_sum > sevm_pkg::SAMPLE_TOP) begin
      mix_sample = 8'd255;
    end else begin
      mix_sample = mix_sum[7:0];
    end
  end

  assign melody_setup = slots[melody_position[POS_W-1:0]];
  assign count_sat    = (32'(pend_count) > MELODY_SLOTS) ? LEN_W'(MELODY_SLOTS)
                                                         : LEN_W'(pend_count);
  assign slot_write   = consume && pend_op == sevm_pkg::OP_SLOT_WRITE &&
                        32'(pend_slot) < MELODY_SLOTS;

  always_comb begin
    noise_next           = noise;
    lowpass_next         = lowpass;
    hiss_target_next     = hiss_target;
    hiss_level_next      = hiss_level;
    crackle_next         = crackle;
    phase_acc_next       = phase_acc;
    tone_inc_next        = tone_inc;
    note_level_next      = note_level;
    tone_remaining_next  = tone_remaining;
    melody_length_next   = melody_length;
    melody_position_next = melody_position;
    gap_count_next       = gap_count;
    out_valid_next       = out_valid && !out_ready;
    sample_next          = sample;
    pend_valid_next      = pend_valid && !consume;
    if (in_valid && in_ready) begin
      pend_valid_next = 1'b1;
    end

    if (consume) begin
      case (pend_op)
        sevm_pkg::OP_TICK: begin
          hiss_level_next = hiss_level_mix;
          noise_next      = r3;
          lowpass_next    = lp_mix;
          if (crackle != 8'd0) begin
            crackle_next = crackle_mix;
          end
          if (tone_remaining != 13'd0) begin
            phase_acc_next      = phase_mix;
            tone_remaining_next = remaining_mix;
            if (remaining_mix < {6'd0, melody_gap}) begin
              note_level_next = amp_faded;
            end
          end else if (melody_position < melody_length) begin
            if (gap_count != 7'd0) begin
              gap_count_next = gap_count - 7'd1;
            end else begin
              tone_inc_next        = melody_setup.inc;
              phase_acc_next       = 32'd0;
              note_level_next      = $signed({2'b00, melody_amplitude});
              tone_remaining_next  = melody_setup.len;
              melody_position_next = melody_position + LEN_W'(1);
              gap_count_next       = melody_gap;
            end
          end
          out_valid_next = 1'b1;
          sample_next    = mix_sample;
        end
        sevm_pkg::OP_HISS_TARGET: begin
          hiss_target_next = pend_amount;
        end
        sevm_pkg::OP_CRACKLE_SET: begin
          crackle_next = pend_amount;
        end
        sevm_pkg::OP_CRACKLE_RAISE: begin
          if (crackle < pend_amount) begin
            crackle_next = pend_amount;
          end
        end
        sevm_pkg::OP_NOTE: begin
          tone_inc_next       = pend_setup.inc;
          phase_acc_next      = 32'd0;
          note_level_next     = $signed({2'b00, pend_amount});
          tone_remaining_next = pend_setup.len;
        end
        sevm_pkg::OP_SLOT_WRITE: begin
          // The slot store itself is written in the clocked block.
        end
        sevm_pkg::OP_MELODY_START: begin
          melody_length_next   = count_sat;
          melody_position_next = '0;
          gap_count_next       = 7'd0;
        end
        sevm_pkg::OP_SILENCE: begin
          hiss_target_next     = 8'd0;
          hiss_level_next      = 8'd0;
          crackle_next         = 8'd0;
          note_level_next      = 10'sd0;
          tone_remaining_next  = 13'd0;
          melody_length_next   = '0;
          melody_position_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pend_op     <= sevm_pkg::op_t'(operation);
      pend_amount <= amount;
      pend_slot   <= slot;
      pend_count  <= count;
      pend_setup  <= port_setup;
    end
    sample <= sample_next;
    if (rst) begin
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
      melody_amplitude <= sevm_pkg::MELODY_AMPLITUDE_RESET;
      melody_gap       <= sevm_pkg::MELODY_GAP_RESET;
      noise            <= sevm_pkg::NOISE_SEED;
      lowpass          <= 8'sd0;
      hiss_target      <= 8'd0;
      hiss_level       <= 8'd0;
      crackle          <= 8'd0;
      phase_acc        <= 32'd0;
      tone_inc         <= 32'd0;
      note_level       <= 10'sd0;
      tone_remaining   <= 13'd0;
      melody_length    <= '0;
      melody_position  <= '0;
      gap_count        <= 7'd0;
      for (int i = 0; i < MELODY_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else begin
      pend_valid      <= pend_valid_next;
      out_valid       <= out_valid_next;
      noise           <= noise_next;
      lowpass         <= lowpass_next;
      hiss_target     <= hiss_target_next;
      hiss_level      <= hiss_level_next;
      crackle         <= crackle_next;
      phase_acc       <= phase_acc_next;
      tone_inc        <= tone_inc_next;
      note_level      <= note_level_next;
      tone_remaining  <= tone_remaining_next;
      melody_length   <= melody_length_next;
      melody_position <= melody_position_next;
      gap_count       <= gap_count_next;
      if (slot_write) begin
        slots[POS_W'(pend_slot)] <= pend_setup;
      end
      if (cfg_we) begin
        case (cfg_index)
          sevm_pkg::REG_MELODY_AMPLITUDE: melody_amplitude <= cfg_data;
          sevm_pkg::REG_MELODY_GAP:       melody_gap       <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The end fade settles at -8 and never goes further down.
  assert property (@(posedge clk) disable iff (rst) note_level >= sevm_pkg::AMP_FLOOR)
    else $error("tone amplitude below fade floor");

  assert property (@(posedge clk) disable iff (rst) melody_position <= melody_length)
    else $error("melody position past melody length");

  // Every tick that leaves the input register produces a sample beat.
  assert property (@(posedge clk) disable iff (rst)
    consume && pend_op == sevm_pkg::OP_TICK |=> out_valid && sample == $past(mix_sample))
    else $error("tick did not load a sample");

  // A command that cannot move on stays in the input register.
  assert property (@(posedge clk) disable iff (rst)
    pend_valid && !consume |=> pend_valid && $stable(pend_op))
    else $error("stalled command lost");
`endif

endmodule

// ----- verif/tb_sound_effect_voice_mixer_core.sv -----
module tb_sound_effect_voice_mixer_core;

  localparam int VOICE_SLOTS   = 8;
  localparam int PHASE_BEATS   = 125;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 4;

  typedef struct packed {
    sevm_pkg::op_t op;
    logic [7:0]  amount;
    logic [15:0] freq;
    logic [7:0]  dur;
    logic [2:0]  slot;
    logic [3:0]  count;
    logic        typed;
    logic [7:0]  typed_sample;
  } cmd_t;

  // Rows with typed set carry a sample that is obvious by inspection; the rest are
  // checked against the mixer model below.
  localparam cmd_t DIRECTED_ROWS [25] = '{
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b1, 8'd128},
    '{sevm_pkg::OP_HISS_TARGET,   8'd255, 16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_CRACKLE_SET,   8'd255, 16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_CRACKLE_RAISE, 8'd10,  16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_CRACKLE_SET,   8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_CRACKLE_RAISE, 8'd200, 16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_SILENCE,       8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b1, 8'd128},
    '{sevm_pkg::OP_NOTE,          8'd255, 16'd0,     8'd255, 3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b1, 8'd0},
    '{sevm_pkg::OP_NOTE,          8'd200, 16'd65535, 8'd1,   3'd7, 4'd15, 1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd255, 16'd65535, 8'd255, 3'd7, 4'd15, 1'b0, 8'd0},
    '{sevm_pkg::OP_SLOT_WRITE,    8'd0,   16'd65535, 8'd255, 3'd7, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_SLOT_WRITE,    8'd0,   16'd440,   8'd2,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_MELODY_START,  8'd0,   16'd0,     8'd0,   3'd0, 4'd15, 1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_SILENCE,       8'd255, 16'd65535, 8'd255, 3'd7, 4'd15, 1'b0, 8'd0},
    '{sevm_pkg::OP_MELODY_START,  8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b0, 8'd0},
    '{sevm_pkg::OP_TICK,          8'd0,   16'd0,     8'd0,   3'd0, 4'd0,  1'b1, 8'd128}
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [2:0] operation;
  logic [7:0] amount;
  logic [15:0] freq_hz;
  logic [7:0] duration_ms;
  logic [2:0] slot;
  logic [3:0] count;
  logic out_valid;
  logic out_ready;
  logic [7:0] sample;
  logic cfg_we;
  logic [sevm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sevm_pkg::CFG_DATA_W-1:0] cfg_data;

  cmd_t cur_cmd;
  int unsigned idle_pct;
  logic hold_off_req;
  logic [7:0] expected_samples[$];
  int unsigned mismatches;
  int unsigned stall_cycles;

  // Mixer model state.
  bit [31:0]   noise_state;
  int          lowpass_acc;
  int          hiss_goal;
  int          hiss_now;
  int          crackle_now;
  bit [31:0]   phase_acc;
  bit [31:0]   phase_step;
  int          note_level;
  int unsigned note_samples;
  logic [15:0] tune_freq [VOICE_SLOTS];
  logic [7:0]  tune_ms [VOICE_SLOTS];
  int unsigned tune_len;
  int unsigned tune_pos;
  int unsigned tune_wait;
  int unsigned note_amp_cfg;
  int unsigned gap_cfg;

  sound_effect_voice_mixer_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .amount(amount),
    .freq_hz(freq_hz),
    .duration_ms(duration_ms),
    .slot(slot),
    .count(count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample(sample),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void reset_mixer_model();
    noise_state = sevm_pkg::NOISE_SEED;
    lowpass_acc = 0;
    hiss_goal = 0;
    hiss_now = 0;
    crackle_now = 0;
    phase_acc = '0;
    phase_step = '0;
    note_level = 0;
    note_samples = 0;
    for (int i = 0; i < VOICE_SLOTS; i++) begin
      tune_freq[i] = '0;
      tune_ms[i] = '0;
    end
    tune_len = 0;
    tune_pos = 0;
    tune_wait = 0;
    note_amp_cfg = sevm_pkg::MELODY_AMPLITUDE_RESET;
    gap_cfg = sevm_pkg::MELODY_GAP_RESET;
  endfunction

  function automatic void load_tone(logic [15:0] hz, logic [7:0] ms, logic [7:0] amp);
    longint unsigned len;
    phase_step = 32'((64'(hz) << 32) / sevm_pkg::SAMPLE_RATE);
    phase_acc = '0;
    note_level = int'(amp);
    len = 64'(ms) * sevm_pkg::SAMPLE_RATE / sevm_pkg::MS_PER_SECOND;
    note_samples = (len > 64'(sevm_pkg::TONE_LEN_MAX)) ? int'(sevm_pkg::TONE_LEN_MAX)
                                                       : int'(len);
  endfunction

  function automatic logic [7:0] mix_next_sample();
    int acc;
    int nz;
    acc = 0;
    hiss_now += (hiss_goal - hiss_now) >>> 5;
    noise_state ^= noise_state << 13;
    noise_state ^= noise_state >> 17;
    noise_state ^= noise_state << 5;
    nz = int'(noise_state[15:8]) - 128;
    lowpass_acc += (nz - lowpass_acc) >>> 2;
    acc += (lowpass_acc * hiss_now) >>> 8;

    if (crackle_now > 0) begin
      acc += (nz * crackle_now) >>> 8;
      crackle_now -= (crackle_now >>> 6) + 1;
    end

    if (note_samples > 0) begin
      phase_acc += phase_step;
      acc += phase_acc[31] ? note_level : -note_level;
      note_samples--;
      // The end fade truncates toward zero, so the amplitude settles slightly negative.
      if (note_samples < gap_cfg) note_level -= note_level / 8 + 1;
    end else if (tune_pos < tune_len) begin
      if (tune_wait > 0) begin
        tune_wait--;
      end else begin
        if (tune_pos < VOICE_SLOTS) begin
          load_tone(tune_freq[tune_pos], tune_ms[tune_pos], 8'(note_amp_cfg));
        end
        tune_pos++;
        tune_wait = gap_cfg;
      end
    end

    acc += 128;
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return 8'(acc);
  endfunction

  function automatic void apply_command(cmd_t c);
    case (c.op)
      sevm_pkg::OP_HISS_TARGET: hiss_goal = int'(c.amount);
      sevm_pkg::OP_CRACKLE_SET: crackle_now = int'(c.amount);
      sevm_pkg::OP_CRACKLE_RAISE: begin
        if (crackle_now < int'(c.amount)) crackle_now = int'(c.amount);
      end
      sevm_pkg::OP_NOTE: load_tone(c.freq, c.dur, c.amount);
      sevm_pkg::OP_SLOT_WRITE: begin
        tune_freq[c.slot] = c.freq;
        tune_ms[c.slot] = c.dur;
      end
      sevm_pkg::OP_MELODY_START: begin
        tune_len = (c.count > VOICE_SLOTS) ? VOICE_SLOTS : int'(c.count);
        tune_pos = 0;
        tune_wait = 0;
      end
      sevm_pkg::OP_SILENCE: begin
        hiss_goal = 0;
        hiss_now = 0;
        crackle_now = 0;
        note_level = 0;
        note_samples = 0;
        tune_len = 0;
        tune_pos = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    c.amount = 8'($urandom);
    c.freq = 16'($urandom);
    c.dur = ($urandom_range(99) < 92) ? 8'($urandom_range(3)) : 8'($urandom);
    c.slot = 3'($urandom);
    c.count = ($urandom_range(99) < 80) ? 4'($urandom_range(8, 1)) : 4'($urandom);
    c.typed = 1'b0;
    c.typed_sample = '0;
    pick = $urandom_range(99);
    if (pick < 55) c.op = sevm_pkg::OP_TICK;
    else if (pick < 60) c.op = sevm_pkg::OP_HISS_TARGET;
    else if (pick < 65) c.op = sevm_pkg::OP_CRACKLE_SET;
    else if (pick < 68) c.op = sevm_pkg::OP_CRACKLE_RAISE;
    else if (pick < 75) c.op = sevm_pkg::OP_NOTE;
    else if (pick < 86) c.op = sevm_pkg::OP_SLOT_WRITE;
    else if (pick < 93) c.op = sevm_pkg::OP_MELODY_START;
    else if (pick < 95) c.op = sevm_pkg::OP_SILENCE;
    else c.op = sevm_pkg::OP_TICK;
    return c;
  endfunction

  // Bookkeeping of every beat, sampled at the rising edge.
  always @(posedge clk) begin
    logic [7:0] want;
    logic [7:0] mixed;
    if (rst) begin
      reset_mixer_model();
      expected_samples.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample %0d with none expected", $time, sample);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want) begin
            $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, sample);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (cur_cmd.op == sevm_pkg::OP_TICK) begin
          mixed = mix_next_sample();
          expected_samples.push_back(cur_cmd.typed ? cur_cmd.typed_sample : mixed);
        end else begin
          apply_command(cur_cmd);
        end
      end
      if (cfg_we) begin
        if (cfg_index == sevm_pkg::REG_MELODY_AMPLITUDE) note_amp_cfg = int'(cfg_data);
        else if (cfg_index == sevm_pkg::REG_MELODY_GAP) gap_cfg = int'(cfg_data[6:0]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL sound_effect_voice_mixer_core");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sample receiver; a hold-off request keeps it stalled long enough to back up the input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_cmd(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cur_cmd = c;
    operation = c.op;
    amount = c.amount;
    freq_hz = c.freq;
    duration_ms = c.dur;
    slot = c.slot;
    count = c.count;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Non-tick commands leave no trace on the output, so allow the pipeline to empty.
  task automatic wait_drained();
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(logic [7:0] amp, logic [6:0] gap);
    cfg_we = 1'b1;
    cfg_index = sevm_pkg::REG_MELODY_AMPLITUDE;
    cfg_data = amp;
    @(negedge clk);
    cfg_index = sevm_pkg::REG_MELODY_GAP;
    cfg_data = {1'($urandom_range(1)), gap};
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = sevm_pkg::OP_TICK;
    amount = '0;
    freq_hz = '0;
    duration_ms = '0;
    slot = '0;
    count = '0;
    cfg_we = 1'b0;
    cfg_index = sevm_pkg::REG_MELODY_AMPLITUDE;
    cfg_data = '0;
    cur_cmd = '0;
    idle_pct = 14;
    hold_off_req = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_ROWS[i]) send_cmd(DIRECTED_ROWS[i]);
    in_valid = 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: write_config(8'd255, 7'd0);
        1: write_config(8'd0, 7'd127);
        2: write_config(8'($urandom), 7'd2);
        default: write_config(8'($urandom), 7'($urandom_range(20)));
      endcase
      // The third phase runs without any idle cycles on either side.
      idle_pct = (phase == 2) ? 0 : 14;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 0 && n == 40) hold_off_req = 1'b1;
        send_cmd(random_cmd());
      end
      in_valid = 1'b0;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("PASS sound_effect_voice_mixer_core");
    end else begin
      $display("FAIL sound_effect_voice_mixer_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sevm_pkg.sv
hw/rtl/sevm_tone_calc.sv
hw/rtl/sound_effect_voice_mixer_core.sv
verif/tb_sound_effect_voice_mixer_core.sv
